### hdl/hbtm_pkg.sv
// hbtm_pkg: shared types and constants of the heartbeat timeout monitor.
// Transaction structs, chain token and cell status types.
// No dependencies.
`default_nettype none

package hbtm_pkg;

	localparam int CHANNELS   = 32;
	localparam int CHAN_IDX_W = $clog2(CHANNELS + 1);

	localparam logic [CHAN_IDX_W-1:0] CHAN_NONE = CHAN_IDX_W'(CHANNELS);

	localparam logic [9:0] SCAN_PERIOD_RST = 10'd2;
	localparam logic       REG_SCAN_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_ARRIVE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_LOAD   = 2'd3
	} req_e;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  channel;
		logic        data_error;
		logic [4:0]  range_start;
		logic [4:0]  range_end;
		logic        find_error;
		logic [15:0] offline_ticks;
		logic [15:0] online_ticks;
		logic [7:0]  priority_req;
		logic        enable;
	} hb_in_t;

	typedef struct packed {
		logic [31:0] error_bitmap;
		logic [31:0] lost_bitmap;
		logic        any_lost;
		logic [5:0]  display_channel;
		logic        scanned;
		logic        data_error_event;
		logic        query_found;
		logic [4:0]  query_index;
	} hb_out_t;

	// token handed from cell to cell, one hop per cycle
	typedef struct packed {
		logic                  valid;
		logic                  scan;
		hb_in_t                item;
		logic [CHAN_IDX_W-1:0] idx;
		logic [7:0]            best_pri;
		logic [CHAN_IDX_W-1:0] best_idx;
		logic                  found;
		logic [4:0]            qidx;
	} hb_tok_t;

	typedef struct packed {
		logic err;
		logic hit;
	} cell_stat_t;

endpackage

`default_nettype wire

### hdl/hbtm_cell.sv
// hbtm_cell: one channel of the watchdog chain; holds that channel's state
// and forwards the token to its neighbor. Depends on hbtm_pkg.
`default_nettype none

module hbtm_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [31:0]         now,
	input  wire hbtm_pkg::hb_tok_t   tok_in,
	output hbtm_pkg::hb_tok_t        tok_out,
	output hbtm_pkg::cell_stat_t     stat
);
	import hbtm_pkg::*;

	logic        en_q, err_q, lost_q, derr_q, hit_q;
	logic [31:0] last_q, since_q;
	logic [15:0] offl_q, onl_q;
	logic [7:0]  prio_q;
	hb_tok_t     tok_q;

	logic        sel, is_off, unstable, in_range, scan_here, query_here;
	logic [31:0] age_last, age_since;
	hb_tok_t     tok_d;

	always_comb begin
		sel        = tok_in.idx == {1'b0, tok_in.item.channel};
		age_last   = now - last_q;
		age_since  = now - since_q;
		is_off     = age_last > {16'd0, offl_q};
		unstable   = age_since < {16'd0, onl_q};
		in_range   = (tok_in.idx >= {1'b0, tok_in.item.range_start}) &&
			(tok_in.idx <= {1'b0, tok_in.item.range_end});
		scan_here  = tok_in.valid && tok_in.scan && en_q;
		query_here = tok_in.valid && (tok_in.item.req_type == REQ_QUERY) &&
			(tok_in.item.range_start <= tok_in.item.range_end);

		tok_d     = tok_in;
		tok_d.idx = tok_in.idx + 1'b1;
		if (scan_here && is_off && (prio_q > tok_in.best_pri)) begin
			tok_d.best_pri = prio_q;
			tok_d.best_idx = tok_in.idx;
		end
		if (query_here && !tok_in.found && in_range && (err_q == tok_in.item.find_error)) begin
			tok_d.found = 1'b1;
			tok_d.qidx  = tok_in.idx[4:0];
		end
	end

	// flags and token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			err_q  <= 1'b0;
			lost_q <= 1'b0;
			derr_q <= 1'b0;
			hit_q  <= 1'b0;
			tok_q  <= '0;
		end else begin
			tok_q <= tok_d;
			if (tok_in.valid) begin
				hit_q <= scan_here && is_off;
				if (scan_here) begin
					if (is_off) begin
						if (!err_q) begin
							lost_q <= 1'b1;
							err_q  <= 1'b1;
						end
					end else if (unstable) begin
						lost_q <= 1'b0;
						err_q  <= 1'b1;
					end else begin
						lost_q <= 1'b0;
						err_q  <= derr_q;
					end
				end else if (sel && tok_in.item.req_type == REQ_ARRIVE) begin
					lost_q <= 1'b0;
					if (tok_in.item.data_error) begin
						err_q  <= 1'b1;
						derr_q <= 1'b1;
					end else begin
						derr_q <= 1'b0;
					end
				end else if (sel && tok_in.item.req_type == REQ_LOAD) begin
					en_q   <= tok_in.item.enable;
					err_q  <= 1'b1;
					lost_q <= 1'b1;
					derr_q <= 1'b1;
				end
			end
		end
	end

	// timestamps and settings, undefined until loaded
	always_ff @(posedge clk) begin
		if (tok_in.valid && sel) begin
			if (tok_in.item.req_type == REQ_ARRIVE) begin
				last_q <= now;
				if (lost_q)
					since_q <= now;
			end else if (tok_in.item.req_type == REQ_LOAD) begin
				last_q  <= now;
				since_q <= now;
				offl_q  <= tok_in.item.offline_ticks;
				onl_q   <= tok_in.item.online_ticks;
				prio_q  <= tok_in.item.priority_req;
			end
		end
	end

	assign tok_out  = tok_q;
	assign stat.err = err_q;
	assign stat.hit = hit_q;

endmodule

`default_nettype wire

### hdl/heartbeat_timeout_monitor_unit.sv
// heartbeat_timeout_monitor_unit: top level of the multi-channel watchdog.
// Uses hbtm_pkg and a row of CHANNELS hbtm_cell instances.
//
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------
// request | start & !busy        | cmd  (hbtm_pkg::hb_in_t)
// result  | done, one cycle      | rsp  (hbtm_pkg::hb_out_t)
// config  | APB write, pready=1  | scan_period at byte address 0
//
// Every transaction walks its token from the launch register through the
// cell row, one cell per clock, and the result is registered from the
// last cell's output into rsp.
// busy drops on the cycle done is shown, so the next transaction may be
// taken while the result is on rsp. done lasts exactly one cycle; the
// receiver has no way to stall it. Reset clears all channel flags
// (channels disabled), the tick counter, the scan countdown and the
// aggregate lost flag; scan_period resets to 2.
`default_nettype none

module heartbeat_timeout_monitor_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire hbtm_pkg::hb_in_t  cmd,
	output logic                   done,
	output hbtm_pkg::hb_out_t      rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import hbtm_pkg::*;

	logic [9:0]  scan_period_q;
	logic [31:0] now_q;
	logic [9:0]  countdown_q;
	logic        agg_lost_q;
	logic        busy_q;
	logic        done_q;
	hb_out_t     rsp_q;
	hb_tok_t     launch_q;

	hb_tok_t     tok [CHANNELS+1];
	cell_stat_t  stat [CHANNELS];

	logic        accept, finish, cfg_wr, scan_now;
	logic [9:0]  period_eff;
	logic [31:0] err_bits, lost_bits;
	hb_tok_t     tok_end;
	hb_out_t     rsp_d;

	assign accept     = start && !busy_q;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign period_eff = (scan_period_q == 10'd0) ? 10'd1 : scan_period_q;
	assign scan_now   = (cmd.req_type == REQ_TICK) && (countdown_q == 10'd0);
	assign tok[0]     = launch_q;
	assign tok_end    = tok[CHANNELS];
	assign finish     = tok_end.valid;

	// cell row
	for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
		hbtm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.now     (now_q),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.stat    (stat[g])
		);
	end

	// gather per-channel status once the token has left the last cell
	always_comb begin
		err_bits  = '0;
		lost_bits = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			err_bits[i]  = stat[i].err;
			lost_bits[i] = stat[i].hit;
		end
	end

	always_comb begin
		rsp_d                  = '0;
		rsp_d.error_bitmap     = err_bits;
		rsp_d.lost_bitmap      = tok_end.scan ? lost_bits : 32'd0;
		rsp_d.any_lost         = tok_end.scan ? (|lost_bits) : agg_lost_q;
		rsp_d.display_channel  = 6'(tok_end.best_idx);
		rsp_d.scanned          = tok_end.scan;
		rsp_d.data_error_event = (tok_end.item.req_type == REQ_ARRIVE) &&
			tok_end.item.data_error &&
			({1'b0, tok_end.item.channel} < CHAN_NONE);
		if (tok_end.item.req_type == REQ_QUERY) begin
			if (tok_end.item.range_start > tok_end.item.range_end) begin
				rsp_d.query_found = 1'b1;
			end else if (tok_end.found) begin
				rsp_d.query_found = 1'b1;
				rsp_d.query_index = tok_end.qidx;
			end else if (!tok_end.item.find_error &&
				({1'b0, tok_end.item.range_end} >= CHAN_NONE)) begin
				// channels past the row read as healthy
				rsp_d.query_found = 1'b1;
				rsp_d.query_index = ({1'b0, tok_end.item.range_start} >= CHAN_NONE) ?
					tok_end.item.range_start : 5'(CHANNELS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
			now_q         <= '0;
			countdown_q   <= '0;
			agg_lost_q    <= 1'b0;
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			launch_q      <= '0;
		end else begin
			if (cfg_wr && paddr[2] == REG_SCAN_PERIOD)
				scan_period_q <= pwdata[9:0];

			launch_q.valid <= accept;
			if (accept) begin
				busy_q            <= 1'b1;
				launch_q.scan     <= scan_now;
				launch_q.item     <= cmd;
				launch_q.idx      <= '0;
				launch_q.best_pri <= '0;
				launch_q.best_idx <= CHAN_NONE;
				launch_q.found    <= 1'b0;
				launch_q.qidx     <= '0;
				if (cmd.req_type == REQ_TICK) begin
					now_q <= now_q + 32'd1;
					if (countdown_q == 10'd0)
						countdown_q <= period_eff - 10'd1;
					else
						countdown_q <= countdown_q - 10'd1;
				end
			end

			done_q <= finish;
			if (finish) begin
				busy_q     <= 1'b0;
				agg_lost_q <= rsp_d.any_lost;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish)
			rsp_q <= rsp_d;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SCAN_PERIOD) ? {22'd0, scan_period_q} : 32'd0;

endmodule

`default_nettype wire

### tb/hbtm_checker.sv
// hbtm_checker: predicts every result of the heartbeat timeout monitor and compares it.
// Watches the command, result and APB channels; keeps its own copy of the channel state.
// Depends on hbtm_pkg.

module hbtm_checker import hbtm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  hb_in_t      cmd,
	input  logic        done,
	input  hb_out_t     rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	localparam logic [2:0] SCAN_PERIOD_ADDR = 3'(4 * REG_SCAN_PERIOD);

	// mirrored block state
	logic [9:0]          period;
	logic [31:0]         tick_now;
	logic [9:0]          scan_wait;
	logic [31:0]         last_seen  [CHANNELS];
	logic [31:0]         up_since   [CHANNELS];
	logic [15:0]         offline_lim[CHANNELS];
	logic [15:0]         settle_lim [CHANNELS];
	logic [7:0]          chan_pri   [CHANNELS];
	logic [CHANNELS-1:0] chan_en, chan_err, chan_lost, chan_derr;
	logic                any_down;

	hb_out_t expected_status[$];

	task automatic scan_channels(output logic [31:0] down_bits, output logic [5:0] shown);
		logic [7:0]  best;
		logic [31:0] age, up;
		down_bits = '0;
		shown     = CHAN_NONE;
		best      = '0;
		any_down  = 1'b0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (chan_en[ch]) begin
				age = tick_now - last_seen[ch];
				up  = tick_now - up_since[ch];
				if (age > 32'(offline_lim[ch])) begin
					// a channel already in error does not get lost again
					if (!chan_err[ch]) begin
						chan_lost[ch] = 1'b1;
						chan_err[ch]  = 1'b1;
					end
					// strict compare: first channel wins ties, priority 0 never shown
					if (chan_pri[ch] > best) begin
						best  = chan_pri[ch];
						shown = 6'(ch);
					end
					any_down      = 1'b1;
					down_bits[ch] = 1'b1;
				end else if (up < 32'(settle_lim[ch])) begin
					chan_lost[ch] = 1'b0;
					chan_err[ch]  = 1'b1;
				end else begin
					chan_lost[ch] = 1'b0;
					chan_err[ch]  = chan_derr[ch];
				end
			end
		end
	endtask

	task automatic predict_status(input hb_in_t c, output hb_out_t r);
		logic [9:0] eff_period;
		r                 = '0;
		r.display_channel = CHAN_NONE;
		case (c.req_type)
			REQ_TICK: begin
				eff_period = (period == '0) ? 10'd1 : period;
				tick_now   = tick_now + 32'd1;
				if (scan_wait == '0) begin
					scan_channels(r.lost_bitmap, r.display_channel);
					r.scanned = 1'b1;
					scan_wait = eff_period - 10'd1;
				end else begin
					scan_wait = scan_wait - 10'd1;
				end
			end
			REQ_ARRIVE: begin
				last_seen[c.channel] = tick_now;
				if (chan_lost[c.channel]) begin
					chan_lost[c.channel] = 1'b0;
					up_since[c.channel]  = tick_now;
				end
				if (c.data_error) begin
					chan_err[c.channel]  = 1'b1;
					chan_derr[c.channel] = 1'b1;
					r.data_error_event   = 1'b1;
				end else begin
					chan_derr[c.channel] = 1'b0;
				end
			end
			REQ_QUERY: begin
				r.query_found = 1'b1;
				if (c.range_start <= c.range_end) begin
					r.query_found = 1'b0;
					for (int ch = int'(c.range_start); ch <= int'(c.range_end); ch++) begin
						if (!r.query_found && chan_err[ch] == c.find_error) begin
							r.query_found = 1'b1;
							r.query_index = 5'(ch);
						end
					end
				end
			end
			default: begin
				offline_lim[c.channel] = c.offline_ticks;
				settle_lim[c.channel]  = c.online_ticks;
				chan_pri[c.channel]    = c.priority_req;
				chan_en[c.channel]     = c.enable;
				chan_err[c.channel]    = 1'b1;
				chan_lost[c.channel]   = 1'b1;
				chan_derr[c.channel]   = 1'b1;
				last_seen[c.channel]   = tick_now;
				up_since[c.channel]    = tick_now;
			end
		endcase
		r.error_bitmap = chan_err;
		r.any_lost     = any_down;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		hb_out_t want;
		int      delta;
		if (!arst_n) begin
			period    = SCAN_PERIOD_RST;
			tick_now  = '0;
			scan_wait = '0;
			any_down  = 1'b0;
			chan_en   = '0;
			chan_err  = '0;
			chan_lost = '0;
			chan_derr = '0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				last_seen[ch]   = '0;
				up_since[ch]    = '0;
				offline_lim[ch] = '0;
				settle_lim[ch]  = '0;
				chan_pri[ch]    = '0;
			end
			expected_status.delete();
			fail_count = 0;
			pending   <= 0;
		end else begin
			delta = 0;
			if (done) begin
				if (expected_status.size() == 0) begin
					$error("result with no transaction outstanding: %h", rsp);
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					check_field("error_bitmap", want.error_bitmap, rsp.error_bitmap);
					check_field("lost_bitmap", want.lost_bitmap, rsp.lost_bitmap);
					check_field("any_lost", 32'(want.any_lost), 32'(rsp.any_lost));
					check_field("display_channel", 32'(want.display_channel),
						32'(rsp.display_channel));
					check_field("scanned", 32'(want.scanned), 32'(rsp.scanned));
					check_field("data_error_event", 32'(want.data_error_event),
						32'(rsp.data_error_event));
					check_field("query_found", 32'(want.query_found), 32'(rsp.query_found));
					check_field("query_index", 32'(want.query_index), 32'(rsp.query_index));
					delta--;
				end
			end
			if (psel && penable && pwrite && pready && paddr == SCAN_PERIOD_ADDR)
				period = pwdata[9:0];
			if (start && !busy) begin
				predict_status(cmd, want);
				expected_status.push_back(want);
				delta++;
			end
			pending <= pending + delta;
		end
	end

endmodule

### tb/testbench.sv
// testbench: top of the heartbeat timeout monitor test; drives commands and APB writes.
// Instantiates heartbeat_timeout_monitor_unit and hbtm_checker, gives the verdict.
// Depends on hbtm_pkg.

module testbench;
	import hbtm_pkg::*;

	localparam int         QUIET_LIMIT      = 4000; // cycles without any transaction
	localparam int         END_CYCLES       = 48;   // longer than one transaction takes
	localparam int         PHASE_ITEMS      = 212;
	localparam int         PHASES           = 8;
	localparam logic [2:0] SCAN_PERIOD_ADDR = 3'(4 * REG_SCAN_PERIOD);

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	hb_in_t      cmd     = '0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic        busy, done, pready;
	hb_out_t     rsp;
	logic [31:0] prdata;

	int fail_count, pending;
	int idle_pct;    // chance in percent that the command side sits out a cycle
	int quiet;

	always #4 clk = ~clk;

	heartbeat_timeout_monitor_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hbtm_checker status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.rsp        (rsp),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// --- request builders ---------------------------------------------------
	// Every request starts from random bits so that fields the block ignores
	// for a given request type still toggle.
	function automatic hb_in_t noise();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[$bits(hb_in_t)-1:0];
	endfunction

	function automatic hb_in_t req_tick();
		hb_in_t r;
		r          = noise();
		r.req_type = REQ_TICK;
		return r;
	endfunction

	function automatic hb_in_t req_arrive(input logic [4:0] ch, input logic derr);
		hb_in_t r;
		r            = noise();
		r.req_type   = REQ_ARRIVE;
		r.channel    = ch;
		r.data_error = derr;
		return r;
	endfunction

	function automatic hb_in_t req_query(input logic [4:0] lo, input logic [4:0] hi,
			input logic want_err);
		hb_in_t r;
		r             = noise();
		r.req_type    = REQ_QUERY;
		r.range_start = lo;
		r.range_end   = hi;
		r.find_error  = want_err;
		return r;
	endfunction

	function automatic hb_in_t req_load(input logic [4:0] ch, input logic [15:0] off_t,
			input logic [15:0] on_t, input logic [7:0] pri, input logic en);
		hb_in_t r;
		r               = noise();
		r.req_type      = REQ_LOAD;
		r.channel       = ch;
		r.offline_ticks = off_t;
		r.online_ticks  = on_t;
		r.priority_req  = pri;
		r.enable        = en;
		return r;
	endfunction

	// Random traffic shaped to keep channels cycling through online, unstable
	// and lost: mostly ticks and arrivals, loads with short limits so a few
	// dozen ticks are enough to lose a channel, occasional full-range values.
	function automatic hb_in_t random_request();
		int          pick;
		logic [4:0]  lo, hi;
		logic [15:0] off_t, on_t;
		logic [7:0]  pri;
		pick = $urandom_range(99);
		if (pick < 43)
			return req_tick();
		if (pick < 73)
			return req_arrive(5'($urandom_range(31)), $urandom_range(99) < 30);
		if (pick < 88) begin
			lo = 5'($urandom_range(31));
			hi = 5'($urandom_range(31));
			// mostly well-formed ranges, some with start above end
			if (lo > hi && $urandom_range(99) < 70)
				return req_query(hi, lo, 1'($urandom_range(1)));
			return req_query(lo, hi, 1'($urandom_range(1)));
		end
		case ($urandom_range(9))
			0:       off_t = 16'($urandom());
			1, 2:    off_t = 16'($urandom_range(600));
			default: off_t = 16'($urandom_range(40));
		endcase
		case ($urandom_range(9))
			0:       on_t = 16'($urandom());
			1, 2, 3: on_t = 16'($urandom_range(300));
			default: on_t = 16'($urandom_range(20));
		endcase
		pri = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255));
		return req_load(5'($urandom_range(31)), off_t, on_t, pri, $urandom_range(99) < 85);
	endfunction

	// --- drivers ------------------------------------------------------------
	// Present one transaction and hold it until accepted. start stays high
	// between back-to-back transactions, so it is driven once per step.
	task automatic send(input hb_in_t item);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= item;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted result has come back. pending is
	// registered in the checker, so at least one edge must pass first.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_scan_period(input logic [9:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= SCAN_PERIOD_ADDR;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// --- watchdog -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet < QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// --- stimulus -----------------------------------------------------------
	initial begin : stimulus
		// scan periods per phase: 1 and 1000, zero (acts as 1), small values
		logic [9:0] period_plan [PHASES];
		period_plan = '{10'd1, 10'd0, 10'd1000, 10'd3,
			10'd5, 10'd17, 10'd2, 10'd1000};
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset scan period of 2.
		// Queries with nothing loaded: every channel healthy; then start above end.
		send(req_query(5'd0, 5'd31, 1'b1));
		send(req_query(5'd0, 5'd31, 1'b0));
		send(req_query(5'd31, 5'd0, 1'b1));
		// channel 0: zero limits and zero priority, lost after one tick, never shown
		send(req_load(5'd0, 16'd0, 16'd0, 8'd0, 1'b1));
		// channel 31: maximum limits and priority
		send(req_load(5'd31, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
		// channel 5 ties with 31 on priority, lower index must win
		send(req_load(5'd5, 16'd3, 16'd2, 8'hFF, 1'b1));
		// channel 7 disabled: scans skip it and leave its flags as they are
		send(req_load(5'd7, 16'd10, 16'd5, 8'd200, 1'b0));
		send(req_arrive(5'd5, 1'b1));
		send(req_arrive(5'd5, 1'b0));
		send(req_arrive(5'd7, 1'b1));
		repeat (6) send(req_tick());
		// arrival on a lost channel restarts its stabilization window
		send(req_arrive(5'd0, 1'b0));
		send(req_arrive(5'd5, 1'b0));
		repeat (3) send(req_tick());
		send(req_query(5'd0, 5'd31, 1'b1));
		send(req_query(5'd5, 5'd5, 1'b0));
		send(req_query(5'd31, 5'd31, 1'b1));
		send(req_query(5'd7, 5'd7, 1'b0));
		drain();

		// Random phases: sender idles 16% first, then 62%, then not at all.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_scan_period(period_plan[ph]);
			idle_pct = (ph < 3) ? 16 : (ph < 6) ? 62 : 0;
			repeat (PHASE_ITEMS) begin
				send(random_request());
				// now and then let the block run completely dry
				if ($urandom_range(59) == 0)
					drain();
			end
			drain();
		end

		// quiet period: any late or extra result gets flagged by the checker
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hdl/hbtm_pkg.sv
hdl/hbtm_cell.sv
hdl/heartbeat_timeout_monitor_unit.sv
tb/hbtm_checker.sv
tb/testbench.sv
